>>> hdl/hcdt_pkg.sv
// ----------------------------------------------------------------------------
// hcdt_pkg: shared types and constants of the divider and interval timer
// Item and result layouts, operation and register codes, prescaler periods.
// ----------------------------------------------------------------------------
package hcdt_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_DIV  = 2'd0,
    REG_TIMA = 2'd1,
    REG_TMA  = 2'd2,
    REG_TAC  = 2'd3
  } reg_sel_t;

  localparam int unsigned DivPsW  = 9;
  localparam int unsigned TimPsW  = 11;
  localparam int unsigned CycW    = 5;

  localparam logic [CycW-1:0]   MaxTick    = 5'd16;
  localparam logic [DivPsW-1:0] DivPeriod  = 9'd256;
  localparam int unsigned       EnableBit  = 2;
  localparam logic [7:0]        CountMax   = 8'hff;

  typedef struct packed {
    op_t            op;
    reg_sel_t       reg_sel;
    logic [7:0]     write_data;
    logic [CycW-1:0] tick_cycles;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_irq;
  } result_t;

  // counter prescaler period for control bits 1:0
  function automatic logic [TimPsW-1:0] rate_period(input logic [1:0] rate);
    logic [TimPsW-1:0] p;
    unique case (rate)
      2'd0: p = 11'd1024;
      2'd1: p = 11'd16;
      2'd2: p = 11'd64;
      2'd3: p = 11'd256;
      default: p = 11'd1024;
    endcase
    return p;
  endfunction

endpackage

>>> hdl/hcdt_core.sv
// ----------------------------------------------------------------------------
// hcdt_core: timer register file and its update step
// Holds the four bus registers and both prescalers, applies one item per
// enabled cycle and produces its result combinationally.
// ----------------------------------------------------------------------------
module hcdt_core
  import hcdt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  item_t   item,
  output result_t result
);

  logic [DivPsW-1:0] div_ps_r,  div_ps_nxt;
  logic [TimPsW-1:0] tim_ps_r,  tim_ps_nxt;
  logic [7:0]        div_r,     div_nxt;
  logic [7:0]        tima_r,    tima_nxt;
  logic [7:0]        tma_r,     tma_nxt;
  logic [7:0]        tac_r,     tac_nxt;

  logic [CycW-1:0]   cyc;
  logic [DivPsW-1:0] div_sum;
  logic [TimPsW:0]   tim_sum;
  logic [TimPsW-1:0] limit;

  always_comb begin
    cyc     = (item.tick_cycles > MaxTick) ? MaxTick : item.tick_cycles;
    div_sum = div_ps_r + DivPsW'(cyc);
    tim_sum = {1'b0, tim_ps_r} + (TimPsW + 1)'(cyc);
    limit   = rate_period(tac_r[1:0]);

    div_ps_nxt = div_ps_r;
    tim_ps_nxt = tim_ps_r;
    div_nxt    = div_r;
    tima_nxt   = tima_r;
    tma_nxt    = tma_r;
    tac_nxt    = tac_r;
    result     = '0;

    unique case (item.op)
      OP_TICK: begin
        if (div_sum >= DivPeriod) begin
          div_ps_nxt = div_sum - DivPeriod;
          div_nxt    = div_r + 8'd1;
        end else begin
          div_ps_nxt = div_sum;
        end
        if (tac_r[EnableBit]) begin
          if (tim_sum >= {1'b0, limit}) begin
            tim_ps_nxt = TimPsW'(tim_sum - {1'b0, limit});
            if (tima_r == CountMax) begin
              tima_nxt         = tma_r;
              result.timer_irq = 1'b1;
            end else begin
              tima_nxt = tima_r + 8'd1;
            end
          end else begin
            tim_ps_nxt = TimPsW'(tim_sum);
          end
        end
      end
      OP_READ: begin
        unique case (item.reg_sel)
          REG_DIV:  result.read_data = div_r;
          REG_TIMA: result.read_data = tima_r;
          REG_TMA:  result.read_data = tma_r;
          REG_TAC:  result.read_data = tac_r;
          default:  result.read_data = '0;
        endcase
      end
      OP_WRITE: begin
        unique case (item.reg_sel)
          REG_DIV:  div_nxt  = item.write_data;
          REG_TIMA: tima_nxt = item.write_data;
          REG_TMA:  tma_nxt  = item.write_data;
          REG_TAC:  tac_nxt  = item.write_data;
          default:  ;
        endcase
      end
      OP_NONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_ps_r <= '0;
      tim_ps_r <= '0;
      div_r    <= '0;
      tima_r   <= '0;
      tma_r    <= '0;
      tac_r    <= '0;
    end else if (step_en) begin
      div_ps_r <= div_ps_nxt;
      tim_ps_r <= tim_ps_nxt;
      div_r    <= div_nxt;
      tima_r   <= tima_nxt;
      tma_r    <= tma_nxt;
      tac_r    <= tac_nxt;
    end
  end

endmodule

>>> hdl/handheld_console_divider_timer.sv
// ----------------------------------------------------------------------------
// handheld_console_divider_timer: divider and interval timer
// Stream front end around the timer register file.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  carries one item per transfer: a tick of 0..16 machine cycles, a
//         register read or a register write (op and reg_sel in in_tuser).
//   out_* returns exactly one result per item, in order: the read byte and
//         the timer interrupt flag.
//   An accepted item waits in the input register; the register update and
//   the result capture into the output register happen together once the
//   output register is free. Throughput is one item per cycle while
//   out_tready stays high, set by the single pass through the register file
//   update.
//   When the receiver stalls, the pending result holds in the output
//   register and one more item waits in the input register; in_tready
//   drops only when both are full and out_tready is low.
//   Reset (rst_n low, synchronous) empties both registers and clears the
//   divider, counter, reload, control and both prescalers to zero.
// ----------------------------------------------------------------------------
module handheld_console_divider_timer
  import hcdt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // write_data[7:0], tick_cycles[12:8]
  input  logic [3:0]  in_tuser,   // op[1:0], reg_sel[3:2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // read_data[7:0], timer_irq[8]
);

  logic    in_valid_r, in_valid_nxt;
  item_t   in_item_r;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;
  result_t core_res;
  logic    adv;
  logic    in_acc;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  assign in_valid_nxt  = in_acc || (in_valid_r && !adv);
  assign out_valid_nxt = (in_valid_r && adv) || (out_valid_r && !out_tready);

  hcdt_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_valid_r && adv),
    .item    (in_item_r),
    .result  (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item_r.op          <= op_t'(in_tuser[1:0]);
      in_item_r.reg_sel     <= reg_sel_t'(in_tuser[3:2]);
      in_item_r.write_data  <= in_tdata[7:0];
      in_item_r.tick_cycles <= in_tdata[12:8];
    end
    if (in_valid_r && adv) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.timer_irq, out_res_r.read_data};

  // an interrupt only comes from a tick, which never returns read data
  a_irq_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.timer_irq |-> out_res_r.read_data == 8'd0)
    else $error("interrupt result carries read data");

  // a waiting item is not dropped while the output is blocked
  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !adv |=> in_valid_r && $stable(in_item_r))
    else $error("pending item lost under stall");

  // every item that leaves the input register yields a result
  a_item_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && adv |=> out_valid_r)
    else $error("item advanced without a result");

  // only a read produces nonzero read data
  a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && adv && in_item_r.op != OP_READ |=> out_res_r.read_data == 8'd0)
    else $error("read data on a non-read item");

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stream-level test of the divider and interval timer
// Drives ticks, register reads and register writes through the input stream
// with bursty pacing, stalls the result stream on changing patterns, and
// compares every returned read byte and interrupt flag against a request-level
// model of the four timer registers and their prescalers.
// ----------------------------------------------------------------------------
module tb_top;
  import hcdt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandItems  = 950;
  localparam int unsigned Phases     = 7;
  localparam int unsigned TailCycles = 10;

  typedef enum int unsigned {
    RX_OPEN,
    RX_COIN,
    RX_EVERY4,
    RX_SPARSE
  } rx_mode_e;

  // -------------------------------------------------------------------------
  // timer register model and queue of results still due
  // -------------------------------------------------------------------------
  class timer_scoreboard;
    logic [DivPsW-1:0] div_ps;
    logic [TimPsW-1:0] tim_ps;
    logic [7:0]        div_q;
    logic [7:0]        tima_q;
    logic [7:0]        tma_q;
    logic [7:0]        tac_q;
    int unsigned       step_len [4];
    result_t           due_results [$];
    int unsigned       errors;
    int unsigned       n_tick;
    int unsigned       n_read;
    int unsigned       n_write;
    int unsigned       n_other;
    int unsigned       n_irq;

    function new();
      step_len = '{1024, 16, 64, 256};
      div_ps   = '0;
      tim_ps   = '0;
      div_q    = '0;
      tima_q   = '0;
      tma_q    = '0;
      tac_q    = '0;
      errors   = 0;
      n_tick   = 0;
      n_read   = 0;
      n_write  = 0;
      n_other  = 0;
      n_irq    = 0;
    endfunction

    // update the model for one accepted request and queue its result
    function void apply_request(item_t it);
      result_t     res;
      int unsigned cyc;
      int unsigned acc;
      res = '0;
      case (it.op)
        OP_TICK: begin
          n_tick++;
          // lengths past the maximum count as the maximum
          cyc = (it.tick_cycles > MaxTick) ? MaxTick : it.tick_cycles;
          acc = div_ps + cyc;
          if (acc >= DivPeriod) begin
            acc   = acc - DivPeriod;
            div_q = div_q + 8'd1;
          end
          div_ps = acc[DivPsW-1:0];
          if (tac_q[EnableBit]) begin
            acc = tim_ps + cyc;
            // only one step per tick, so a leftover drains over later ticks
            if (acc >= step_len[tac_q[1:0]]) begin
              acc = acc - step_len[tac_q[1:0]];
              if (tima_q == CountMax) begin
                tima_q        = tma_q;
                res.timer_irq = 1'b1;
                n_irq++;
              end else begin
                tima_q = tima_q + 8'd1;
              end
            end
            tim_ps = acc[TimPsW-1:0];
          end
        end
        OP_READ: begin
          n_read++;
          case (it.reg_sel)
            REG_DIV:  res.read_data = div_q;
            REG_TIMA: res.read_data = tima_q;
            REG_TMA:  res.read_data = tma_q;
            default:  res.read_data = tac_q;
          endcase
        end
        OP_WRITE: begin
          n_write++;
          case (it.reg_sel)
            REG_DIV:  div_q  = it.write_data;
            REG_TIMA: tima_q = it.write_data;
            REG_TMA:  tma_q  = it.write_data;
            default:  tac_q  = it.write_data;
          endcase
        end
        default: n_other++;
      endcase
      due_results.push_back(res);
    endfunction

    function void check_result(logic [15:0] data);
      result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %04h", $time, data);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (data[7:0] !== want.read_data) begin
          $display("%0t: read_data mismatch, expected %02h, actual %02h",
                   $time, want.read_data, data[7:0]);
          errors++;
        end
        if (data[8] !== want.timer_irq) begin
          $display("%0t: timer_irq mismatch, expected %0b, actual %0b",
                   $time, want.timer_irq, data[8]);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // dut and clock
  // -------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;  // write_data[7:0], tick_cycles[12:8]
  logic [3:0]  in_tuser   = '0;  // op[1:0], reg_sel[3:2]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // read_data[7:0], timer_irq[8]

  timer_scoreboard sb = new();
  int unsigned     burst_left = 0;
  int unsigned     cycle_count = 0;

  handheld_console_divider_timer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // result side: stall pattern and checking
  // -------------------------------------------------------------------------
  rx_mode_e    rx_mode = RX_OPEN;
  int unsigned rx_left = 0;
  logic [1:0]  rx_phase = '0;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    rx_phase = rx_phase + 2'd1;
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_EVERY4: out_tready <= (rx_phase == 2'd0);
      default:   out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // values at the falling edge are the ones the next rising edge samples
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // -------------------------------------------------------------------------
  // request side
  // -------------------------------------------------------------------------
  task automatic send_request(op_t op, reg_sel_t sel, logic [7:0] wd, logic [4:0] cyc);
    item_t it;
    logic  ready_seen;
    it.op          = op;
    it.reg_sel     = sel;
    it.write_data  = wd;
    it.tick_cycles = cyc;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 16);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, cyc, wd};
    in_tuser  <= {sel, op};
    do begin
      @(negedge clk);
      ready_seen = in_tready;
      @(posedge clk);
    end while (!ready_seen);
    sb.apply_request(it);
  endtask

  // hold off the sender until every queued result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic send_random(logic [7:0] tac_setting);
    int unsigned pick;
    logic [7:0]  wd;
    logic [4:0]  cyc;
    reg_sel_t    sel;
    pick = $urandom_range(0, 99);
    wd   = 8'($urandom_range(0, 255));
    sel  = reg_sel_t'($urandom_range(0, 3));
    cyc  = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(17, 31))
                                        : 5'($urandom_range(0, 16));
    if (pick < 68) begin
      send_request(OP_TICK, sel, wd, cyc);
    end else if (pick < 84) begin
      send_request(OP_READ, sel, wd, cyc);
    end else if (pick < 97) begin
      // counter writes mostly sit near overflow, control writes keep the rate half the time
      if (sel == REG_TIMA && $urandom_range(0, 9) < 7) begin
        wd = 8'($urandom_range(8'hf0, 8'hff));
      end
      if (sel == REG_TAC && $urandom_range(0, 1) == 0) wd = {wd[7:3], tac_setting[2:0]};
      send_request(OP_WRITE, sel, wd, cyc);
    end else begin
      send_request(OP_NONE, sel, wd, cyc);
    end
  endtask

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  logic [7:0] phase_tac [Phases];

  initial begin
    phase_tac = '{8'h05, 8'h04, 8'h06, 8'h07, 8'h00, 8'hff, 8'hf9};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset values, overflow and reload, clamped ticks, rate change
    send_request(OP_READ,  REG_DIV,  8'h00, 5'd0);
    send_request(OP_READ,  REG_TIMA, 8'hff, 5'd31);
    send_request(OP_READ,  REG_TMA,  8'h00, 5'd0);
    send_request(OP_READ,  REG_TAC,  8'hff, 5'd31);
    send_request(OP_WRITE, REG_TAC,  8'h05, 5'd0);
    send_request(OP_WRITE, REG_TMA,  8'hfe, 5'd0);
    send_request(OP_WRITE, REG_TIMA, 8'hfe, 5'd0);
    send_request(OP_TICK,  REG_DIV,  8'h00, 5'd16);
    send_request(OP_TICK,  REG_TAC,  8'hff, 5'd16);
    send_request(OP_READ,  REG_TIMA, 8'h00, 5'd0);
    send_request(OP_TICK,  REG_DIV,  8'h00, 5'd0);
    send_request(OP_TICK,  REG_DIV,  8'h00, 5'd31);
    send_request(OP_TICK,  REG_DIV,  8'h00, 5'd17);
    send_request(OP_WRITE, REG_DIV,  8'hab, 5'd0);
    send_request(OP_READ,  REG_DIV,  8'h00, 5'd0);
    send_request(OP_WRITE, REG_TAC,  8'h06, 5'd0);
    repeat (3) send_request(OP_TICK, REG_DIV, 8'h00, 5'd16);
    // prescaler left above the faster period drains one step per tick
    send_request(OP_WRITE, REG_TAC,  8'h05, 5'd0);
    repeat (2) send_request(OP_TICK, REG_DIV, 8'h00, 5'd0);
    send_request(OP_READ,  REG_TIMA, 8'h00, 5'd0);
    send_request(OP_WRITE, REG_TAC,  8'h00, 5'd0);
    send_request(OP_TICK,  REG_DIV,  8'h00, 5'd16);
    send_request(OP_NONE,  REG_TAC,  8'hff, 5'd31);
    send_request(OP_WRITE, REG_TAC,  8'hff, 5'd0);
    send_request(OP_READ,  REG_TAC,  8'h00, 5'd0);

    // random: one phase per control setting, sender drained between phases
    for (int p = 0; p < Phases; p++) begin
      drain_results();
      send_request(OP_WRITE, REG_TAC, phase_tac[p], 5'd0);
      send_request(OP_WRITE, REG_TMA, 8'($urandom_range(0, 255)), 5'd0);
      send_request(OP_WRITE, REG_TIMA, 8'($urandom_range(8'he0, 8'hff)), 5'd0);
      for (int n = 0; n < RandItems / Phases; n++) send_random(phase_tac[p]);
    end

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending());
      sb.errors++;
    end

    $display("covered %0d ticks, %0d reads, %0d writes, %0d unused-op requests",
             sb.n_tick, sb.n_read, sb.n_write, sb.n_other);
    $display("all four rates, timer disabled, clamped ticks and %0d counter overflows",
             sb.n_irq);
    if (sb.errors == 0) begin
      $display("handheld_console_divider_timer test passed");
    end else begin
      $display("handheld_console_divider_timer test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: cycle limit reached", $time);
    $display("handheld_console_divider_timer test failed");
    $finish;
  end

endmodule
